@@ hdl/chist_pkg.sv @@
// Shared types, constants and helper functions of the color histogram accumulator.
// Used by the controller, the datapath and the top level; depends on nothing else.
package chist_pkg;

  // Operation codes carried in the lowest bit of the input tuser.
  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Fixed widths of the channel sums and of the count fields on the result beat.
  localparam int SUM_W   = 32;
  localparam int OUT_W   = 24;
  localparam int CHAN_W  = 8;

  // A pixel is opaque when its alpha byte reaches this value.
  localparam logic [CHAN_W-1:0] ALPHA_MIN = 8'hC0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;   // write zero to the current clearing address
    logic take;    // capture the input beat and start the bin read
    logic commit;  // write back the updated bin and the running totals
    logic load;    // load the result register from the bin read
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_read;     // held item is a read operation
    logic out_free;    // result register can take a new beat this cycle
    logic clear_last;  // clearing pass is at its last address
  } status_t;

  // Add an 8-bit channel value to a 32-bit sum, stopping at all ones.
  function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] acc,
                                               input logic [CHAN_W-1:0] inc);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + {{(SUM_W + 1 - CHAN_W){1'b0}}, inc};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

@@ hdl/chist_ctrl.sv @@
// Controller state machine of the color histogram accumulator.
// Sequences the clearing pass and the read/modify/write of each item; uses chist_pkg.
module chist_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  chist_pkg::status_t st,
  output chist_pkg::cmd_t    cmd
);
  import chist_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_LOOK  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (st.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.take   = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        if (!st.is_read) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end else if (st.out_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  // No beat is taken while the bin memory is being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    !(cmd.clear && s_tready))
    else $error("input accepted during clearing pass");

  // An accepted beat is always followed by the bin lookup state.
  a_take_then_look: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_LOOK))
    else $error("accepted beat did not move to lookup");

  // A read waits in place while the result register is still full.
  a_read_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOK && st.is_read && !st.out_free) |=> (state == S_LOOK))
    else $error("read result dropped while output stalled");

  // The result register is only loaded when it is free.
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (st.out_free && st.is_read))
    else $error("result loaded into a full output register");
`endif

endmodule

@@ hdl/chist_dp.sv @@
// Datapath of the color histogram accumulator: bin memory, average bin, totals and
// the result register. Driven by chist_ctrl commands; uses chist_pkg.
module chist_dp #(
  parameter int COUNT_BITS = 24,
  parameter int BIN_BITS   = 15
) (
  input  logic                          clk,
  input  logic                          rst,
  input  chist_pkg::cmd_t               cmd,
  output chist_pkg::status_t            st,
  input  logic                          in_op,
  input  logic [31:0]                   in_pixel,
  input  logic                          in_edge_line,
  input  logic                          in_line_first,
  input  logic                          in_line_last,
  input  logic [15:0]                   in_bin_index,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [3*chist_pkg::SUM_W+4*chist_pkg::OUT_W-1:0] m_tdata
);
  import chist_pkg::*;

  localparam int CH     = BIN_BITS / 3;
  localparam int IDX_W  = 3 * CH;
  localparam int DEPTH  = 1 << BIN_BITS;
  localparam int MEM_W  = 3 * SUM_W + 2 * COUNT_BITS;
  localparam logic [15:0] AVG_SEL = 16'(DEPTH);

  localparam logic [1:0] SRC_MEM  = 2'd0;
  localparam logic [1:0] SRC_AVG  = 2'd1;
  localparam logic [1:0] SRC_NONE = 2'd2;

  // Bin memory, word layout from the lowest bit: red, green, blue, count, edges.
  logic [MEM_W-1:0] mem [0:DEPTH-1];
  logic [MEM_W-1:0] rd_data;
  logic [MEM_W-1:0] wr_data;
  logic [BIN_BITS-1:0] wr_addr;
  logic                mem_we;

  // Held item.
  logic                op_q;
  logic [CHAN_W-1:0]   r_q, g_q, b_q;
  logic                opaque_q;
  logic [1:0]          w_q;
  logic [1:0]          src_q;
  logic [BIN_BITS-1:0] addr_q;

  // Clearing pass address.
  logic [BIN_BITS-1:0] clr_addr;

  // Average bin and running totals.
  logic [SUM_W-1:0]      avg_red, avg_green, avg_blue;
  logic [COUNT_BITS-1:0] avg_count;
  logic [COUNT_BITS-1:0] all_pixels, all_edges;

  // Decode of the input beat.
  logic [CHAN_W-1:0]   px_r, px_g, px_b;
  logic [IDX_W-1:0]    px_idx;
  logic [BIN_BITS-1:0] rd_addr;
  logic [1:0]          src_d;
  logic [1:0]          w_d;

  assign px_r   = in_pixel[23:16];
  assign px_g   = in_pixel[15:8];
  assign px_b   = in_pixel[7:0];
  assign px_idx = {px_r[7 -: CH], px_g[7 -: CH], px_b[7 -: CH]};

  always_comb begin
    if (in_op == OP_READ) begin
      rd_addr = in_bin_index[BIN_BITS-1:0];
    end else begin
      rd_addr = BIN_BITS'(px_idx);
    end
    if ((in_bin_index >> BIN_BITS) == 16'd0) begin
      src_d = SRC_MEM;
    end else if (in_bin_index == AVG_SEL) begin
      src_d = SRC_AVG;
    end else begin
      src_d = SRC_NONE;
    end
    if (in_edge_line) begin
      w_d = 2'd1;
    end else begin
      w_d = {1'b0, in_line_first} + {1'b0, in_line_last};
    end
  end

  // Capture the item when the controller takes the beat.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_q     <= in_op;
      r_q      <= px_r;
      g_q      <= px_g;
      b_q      <= px_b;
      opaque_q <= (in_pixel[31:24] >= ALPHA_MIN);
      w_q      <= w_d;
      src_q    <= src_d;
      addr_q   <= rd_addr;
    end
  end

  // Fields of the bin word read back.
  logic [SUM_W-1:0]      m_red, m_green, m_blue;
  logic [COUNT_BITS-1:0] m_count, m_edges;

  assign m_red   = rd_data[SUM_W-1:0];
  assign m_green = rd_data[2*SUM_W-1:SUM_W];
  assign m_blue  = rd_data[3*SUM_W-1:2*SUM_W];
  assign m_count = rd_data[3*SUM_W+COUNT_BITS-1:3*SUM_W];
  assign m_edges = rd_data[MEM_W-1:3*SUM_W+COUNT_BITS];

  // Saturating count add of a small increment.
  function automatic logic [COUNT_BITS-1:0] sat_cnt(input logic [COUNT_BITS-1:0] acc,
                                                    input logic [1:0] inc);
    logic [COUNT_BITS:0] s;
    s = {1'b0, acc} + {{(COUNT_BITS - 1){1'b0}}, inc};
    return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
  endfunction

  // Updated bin word, or zero during the clearing pass.
  always_comb begin
    if (cmd.clear) begin
      wr_data = '0;
      wr_addr = clr_addr;
    end else begin
      wr_data = {sat_cnt(m_edges, w_q), sat_cnt(m_count, 2'd1),
                 sat_sum(m_blue, b_q), sat_sum(m_green, g_q), sat_sum(m_red, r_q)};
      wr_addr = addr_q;
    end
    mem_we = cmd.clear || (cmd.commit && opaque_q);
  end

  // Bin memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.take) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Clearing pass address counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Average bin and totals.
  always_ff @(posedge clk) begin
    if (rst) begin
      avg_red    <= '0;
      avg_green  <= '0;
      avg_blue   <= '0;
      avg_count  <= '0;
      all_pixels <= COUNT_BITS'(1);
      all_edges  <= COUNT_BITS'(1);
    end else if (cmd.commit) begin
      if (opaque_q) begin
        avg_red   <= sat_sum(avg_red, r_q);
        avg_green <= sat_sum(avg_green, g_q);
        avg_blue  <= sat_sum(avg_blue, b_q);
        avg_count <= sat_cnt(avg_count, 2'd1);
      end
      all_pixels <= sat_cnt(all_pixels, 2'd1);
      all_edges  <= sat_cnt(all_edges, w_q);
    end
  end

  // Counts go out as their low OUT_W bits, zero extended when narrower.
  function automatic logic [OUT_W-1:0] to_out(input logic [COUNT_BITS-1:0] x);
    logic [OUT_W+COUNT_BITS-1:0] wide;
    wide = {{OUT_W{1'b0}}, x};
    return wide[OUT_W-1:0];
  endfunction

  // Result beat selection.
  logic [SUM_W-1:0] res_red, res_green, res_blue;
  logic [OUT_W-1:0] res_count, res_edges;

  always_comb begin
    case (src_q)
      SRC_MEM: begin
        res_red   = m_red;
        res_green = m_green;
        res_blue  = m_blue;
        res_count = to_out(m_count);
        res_edges = to_out(m_edges);
      end
      SRC_AVG: begin
        res_red   = avg_red;
        res_green = avg_green;
        res_blue  = avg_blue;
        res_count = to_out(avg_count);
        res_edges = '0;
      end
      default: begin
        res_red   = '0;
        res_green = '0;
        res_blue  = '0;
        res_count = '0;
        res_edges = '0;
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_tdata <= {to_out(all_edges), to_out(all_pixels), res_edges, res_count,
                  res_blue, res_green, res_red};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Status back to the controller.
  assign st.is_read    = (op_q == OP_READ);
  assign st.out_free   = !m_tvalid || m_tready;
  assign st.clear_last = &clr_addr;

endmodule

@@ hdl/color_histogram_accumulator_core.sv @@
// Color histogram accumulator: ARGB pixels in, bin and total reads out.
// Top level joining chist_ctrl and chist_dp; uses chist_pkg.
//
// Input channel (s_*): one beat per operation. tuser[0] selects the operation:
// accumulate a pixel or read one bin. An accumulate beat adds an opaque pixel
// (alpha at least 0xC0) to the bin picked by the top bits of red, green and blue
// and to the average bin, and always advances the pixel and edge totals. A read
// beat returns one bin (index 2^BIN_BITS is the average bin, higher indexes read
// as zero) together with both totals; accumulate beats return nothing.
// Output channel (m_*): one result beat per read.
// Pacing: a new beat is taken only once the read/modify/write of the last one is
// done (bin read in the accept cycle, write back in the next).
// A read result is loaded into the output register in the lookup state after its
// accept, once that register is free.
// Reset: synchronous; a clearing pass then zeroes all 2^BIN_BITS entries of the bin
// memory (32768 by default), one entry a cycle, with s_tready low. The totals
// restart at 1 and the average bin at zero.
// Stall: a waiting result is held in the output register; the next beat is still
// accepted, and a further read waits until the output register frees up.
module color_histogram_accumulator_core #(
  parameter int COUNT_BITS = 24,
  parameter int BIN_BITS   = 15
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [47:0]  s_tdata,   // pixel[31:0], bin_index[47:32]
  input  logic [2:0]   s_tuser,   // op[0], edge_line[1], line_first[2]
  input  logic         s_tlast,   // line_last
  output logic         m_tvalid,
  input  logic         m_tready,
  // red_sum[31:0], green_sum[63:32], blue_sum[95:64], opaque_count[119:96],
  // edge_weight[143:120], pixel_total[167:144], edge_total[191:168]
  output logic [191:0] m_tdata
);
  import chist_pkg::*;

  cmd_t    cmd;
  status_t st;

  chist_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  chist_dp #(
    .COUNT_BITS (COUNT_BITS),
    .BIN_BITS   (BIN_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .in_op         (s_tuser[0]),
    .in_pixel      (s_tdata[31:0]),
    .in_edge_line  (s_tuser[1]),
    .in_line_first (s_tuser[2]),
    .in_line_last  (s_tlast),
    .in_bin_index  (s_tdata[47:32]),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata)
  );

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for color_histogram_accumulator_core: directed and random
// pixel and read beats, checked against a behavioral histogram kept in this file.
// Depends on chist_pkg and the core RTL.
module testbench;
  import chist_pkg::*;

  localparam int BIN_BITS = 15;
  localparam int COUNT_BITS = 24;
  localparam int CH_BITS = BIN_BITS / 3;
  localparam int AVG_BIN = 1 << BIN_BITS;
  localparam int RANDOM_BEATS = 1530;
  localparam int MAX_REPORTS = 10;
  localparam longint SUM_CAP = 64'hFFFF_FFFF;
  localparam longint COUNT_CAP = (64'd1 << COUNT_BITS) - 1;

  // One operation on the input stream.
  typedef struct packed {
    logic        op;
    logic [31:0] pixel;
    logic        edge_line;
    logic        line_first;
    logic        line_last;
    logic [15:0] bin_index;
  } pixel_beat_t;

  // Result beat; the field order matches the m_tdata packing, lowest field last.
  typedef struct packed {
    logic [OUT_W-1:0] edge_total;
    logic [OUT_W-1:0] pixel_total;
    logic [OUT_W-1:0] edge_weight;
    logic [OUT_W-1:0] opaque_count;
    logic [SUM_W-1:0] blue_sum;
    logic [SUM_W-1:0] green_sum;
    logic [SUM_W-1:0] red_sum;
  } bin_readout_t;

  // Directed row: a beat and, where it is obvious, the readout it must return.
  typedef struct packed {
    pixel_beat_t  beat;
    logic         typed;
    bin_readout_t readout;
  } stimulus_row_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [47:0]  s_tdata;
  logic [2:0]   s_tuser;
  logic         s_tlast;
  logic         m_tvalid;
  logic         m_tready;
  logic [191:0] m_tdata;

  color_histogram_accumulator_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Shadow copy of the bin memory and the running totals.
  logic [SUM_W-1:0]      hist_red   [0:AVG_BIN];
  logic [SUM_W-1:0]      hist_green [0:AVG_BIN];
  logic [SUM_W-1:0]      hist_blue  [0:AVG_BIN];
  logic [COUNT_BITS-1:0] hist_count [0:AVG_BIN];
  logic [COUNT_BITS-1:0] hist_edges [0:AVG_BIN];
  logic [COUNT_BITS-1:0] pixels_seen;
  logic [COUNT_BITS-1:0] edges_seen;

  bin_readout_t  expected_readouts[$];
  stimulus_row_t directed_rows[$];
  int            touched_bins[$];
  bit            steady;
  int            fail_count;
  int            pixel_beats;
  int            opaque_beats;
  int            read_beats;
  int            results_checked;

  function automatic longint clamp_add(input longint acc, input longint inc,
                                       input longint cap);
    return (acc + inc > cap) ? cap : acc + inc;
  endfunction

  // Waits drawn by both sides; none at all during steady stretches.
  function automatic int pick_wait();
    if (steady) return 0;
    return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 19);
  endfunction

  // Readout of any in-range bin right after reset.
  function automatic bin_readout_t fresh_readout();
    bin_readout_t r;
    r = '0;
    r.pixel_total = OUT_W'(1);
    r.edge_total = OUT_W'(1);
    return r;
  endfunction

  task automatic histogram_clear();
    for (int i = 0; i <= AVG_BIN; i++) begin
      hist_red[i] = '0;
      hist_green[i] = '0;
      hist_blue[i] = '0;
      hist_count[i] = '0;
      hist_edges[i] = '0;
    end
    pixels_seen = COUNT_BITS'(1);
    edges_seen = COUNT_BITS'(1);
  endtask

  task automatic add_to_bin(input int bin, input logic [CHAN_W-1:0] red,
                            input logic [CHAN_W-1:0] green, input logic [CHAN_W-1:0] blue);
    hist_red[bin] = SUM_W'(clamp_add(hist_red[bin], red, SUM_CAP));
    hist_green[bin] = SUM_W'(clamp_add(hist_green[bin], green, SUM_CAP));
    hist_blue[bin] = SUM_W'(clamp_add(hist_blue[bin], blue, SUM_CAP));
    hist_count[bin] = COUNT_BITS'(clamp_add(hist_count[bin], 1, COUNT_CAP));
  endtask

  // Applies one accepted beat to the shadow histogram; a read yields a readout.
  task automatic histogram_apply(input pixel_beat_t b, output logic has_readout,
                                 output bin_readout_t r);
    logic [1:0]          weight;
    logic [BIN_BITS-1:0] bin;
    logic [CHAN_W-1:0]   red;
    logic [CHAN_W-1:0]   green;
    logic [CHAN_W-1:0]   blue;
    red = b.pixel[23:16];
    green = b.pixel[15:8];
    blue = b.pixel[7:0];
    r = '0;
    has_readout = (b.op == OP_READ);
    if (b.op == OP_ACCUM) begin
      // Edge lines count once per pixel; other lines once per row-end flag.
      weight = b.edge_line ? 2'd1 : {1'b0, b.line_first} + {1'b0, b.line_last};
      if (b.pixel[31:24] >= ALPHA_MIN) begin
        bin = {red[7 -: CH_BITS], green[7 -: CH_BITS], blue[7 -: CH_BITS]};
        add_to_bin(bin, red, green, blue);
        add_to_bin(AVG_BIN, red, green, blue);
        hist_edges[bin] = COUNT_BITS'(clamp_add(hist_edges[bin], weight, COUNT_CAP));
        touched_bins.push_back(bin);
        opaque_beats++;
      end
      pixels_seen = COUNT_BITS'(clamp_add(pixels_seen, 1, COUNT_CAP));
      edges_seen = COUNT_BITS'(clamp_add(edges_seen, weight, COUNT_CAP));
      pixel_beats++;
    end else begin
      // Indexes past the average bin read the bin fields as zero.
      if (b.bin_index <= AVG_BIN) begin
        r.red_sum = hist_red[b.bin_index];
        r.green_sum = hist_green[b.bin_index];
        r.blue_sum = hist_blue[b.bin_index];
        r.opaque_count = hist_count[b.bin_index];
        r.edge_weight = hist_edges[b.bin_index];
      end
      r.pixel_total = pixels_seen;
      r.edge_total = edges_seen;
      read_beats++;
    end
  endtask

  task automatic report_failure(input string what);
    if (fail_count < MAX_REPORTS) $display("%0t: %s", $time, what);
    fail_count++;
  endtask

  task automatic add_row(input logic op, input logic [31:0] pixel, input logic edge_line,
                         input logic first, input logic last, input logic [15:0] idx,
                         input logic typed, input bin_readout_t readout);
    stimulus_row_t row;
    row.beat.op = op;
    row.beat.pixel = pixel;
    row.beat.edge_line = edge_line;
    row.beat.line_first = first;
    row.beat.line_last = last;
    row.beat.bin_index = idx;
    row.typed = typed;
    row.readout = readout;
    directed_rows.push_back(row);
  endtask

  // Offers one beat after a random gap and records its expectation once accepted.
  task automatic offer_beat(input pixel_beat_t b, input logic typed,
                            input bin_readout_t typed_readout);
    int           gap;
    logic         has_readout;
    bin_readout_t predicted;
    gap = pick_wait();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {b.bin_index, b.pixel};
    s_tuser <= {b.line_first, b.edge_line, b.op};
    s_tlast <= b.line_last;
    do @(posedge clk); while (!s_tready);
    histogram_apply(b, has_readout, predicted);
    if (has_readout) expected_readouts.push_back(typed ? typed_readout : predicted);
  endtask

  // Pixel and read stimulus.
  initial begin
    pixel_beat_t beat;
    logic [23:0] palette [0:7];
    int          pick;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= '0;
    s_tlast <= 1'b0;
    histogram_clear();
    steady = 1'b0;
    for (int i = 0; i < 8; i++) palette[i] = 24'($urandom());
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reads of a fresh histogram, including the average bin and out-of-range indexes.
    add_row(OP_READ, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b1, fresh_readout());
    add_row(OP_READ, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 16'(AVG_BIN), 1'b1, fresh_readout());
    add_row(OP_READ, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 16'(AVG_BIN + 1), 1'b1,
            fresh_readout());
    add_row(OP_READ, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 16'hFFFF, 1'b1, fresh_readout());
    // White on an edge line, black at the alpha threshold with both row-end flags,
    // transparent pixels just under the threshold and at zero, then ordinary pixels.
    add_row(OP_ACCUM, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 16'h0000, 1'b0, '0);
    add_row(OP_ACCUM, 32'hC000_0000, 1'b0, 1'b1, 1'b1, 16'hFFFF, 1'b0, '0);
    add_row(OP_ACCUM, 32'hBFFF_FFFF, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0, '0);
    add_row(OP_ACCUM, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, '0);
    add_row(OP_ACCUM, 32'hFF12_3456, 1'b0, 1'b0, 1'b1, 16'h0000, 1'b0, '0);
    add_row(OP_ACCUM, 32'hC8F8_0808, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, '0);
    add_row(OP_ACCUM, 32'hFF12_3456, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0, '0);
    // Read back every bin touched above, the average bin and the odd indexes.
    add_row(OP_READ, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, '0);
    add_row(OP_READ, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 16'h7FFF, 1'b0, '0);
    add_row(OP_READ, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 16'(AVG_BIN), 1'b0, '0);
    add_row(OP_READ, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 16'(AVG_BIN + 1), 1'b0, '0);
    add_row(OP_READ, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 16'hFFFF, 1'b0, '0);
    add_row(OP_READ, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 16'h08CA, 1'b0, '0);
    add_row(OP_READ, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 16'h7C21, 1'b0, '0);
    add_row(OP_READ, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 16'h0001, 1'b0, '0);
    foreach (directed_rows[i])
      offer_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].readout);

    // Random mix: mostly opaque pixels clustered on a few colors, some reads.
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 100 == 0) steady = ($urandom_range(0, 3) == 0);
      beat.pixel = $urandom();
      beat.bin_index = 16'($urandom());
      beat.edge_line = ($urandom_range(0, 3) == 0);
      beat.line_first = ($urandom_range(0, 3) == 0);
      beat.line_last = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 7) begin
        beat.op = OP_ACCUM;
        pick = $urandom_range(0, 19);
        if (pick < 12) beat.pixel[31:24] = 8'($urandom_range(ALPHA_MIN, 8'hFF));
        else if (pick == 12) beat.pixel[31:24] = ALPHA_MIN;
        else if (pick == 13) beat.pixel[31:24] = ALPHA_MIN - 8'd1;
        if ($urandom_range(0, 1) == 1)
          beat.pixel[23:0] = (palette[$urandom_range(0, 7)] & 24'hF8F8F8)
                             | (beat.pixel[23:0] & 24'h070707);
      end else begin
        beat.op = OP_READ;
        pick = $urandom_range(0, 19);
        if (pick < 8 && touched_bins.size() > 0)
          beat.bin_index = 16'(touched_bins[$urandom_range(0, touched_bins.size() - 1)]);
        else if (pick < 11) beat.bin_index = 16'(AVG_BIN);
        else if (pick < 13) beat.bin_index = 16'($urandom_range(AVG_BIN + 1, 16'hFFFF));
        else if (pick < 17) beat.bin_index = 16'($urandom_range(0, AVG_BIN - 1));
      end
      offer_beat(beat, 1'b0, '0);
    end
    s_tvalid <= 1'b0;

    // Drain the outstanding reads, then watch a little longer for stray beats.
    while (expected_readouts.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Covered %0d pixel beats (%0d opaque) and %0d bin reads; %0d results checked.",
             pixel_beats, opaque_beats, read_beats, results_checked);
    if (fail_count == 0) begin
      $display("PASS color_histogram_accumulator_core");
    end else begin
      $display("%0d result beats did not match.", fail_count);
      $display("FAIL color_histogram_accumulator_core");
    end
    $finish;
  end

  // Result sink with random back-pressure; each beat is checked against the oldest read.
  initial begin
    int           stall;
    string        diffs;
    bin_readout_t got;
    bin_readout_t want;
    m_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = pick_wait();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got = m_tdata;
      results_checked++;
      if (expected_readouts.size() == 0) begin
        report_failure($sformatf("result beat with no read pending: %h", got));
      end else begin
        want = expected_readouts.pop_front();
        diffs = "";
        if (got.red_sum !== want.red_sum)
          diffs = {diffs, $sformatf(" red_sum %0d/%0d", want.red_sum, got.red_sum)};
        if (got.green_sum !== want.green_sum)
          diffs = {diffs, $sformatf(" green_sum %0d/%0d", want.green_sum, got.green_sum)};
        if (got.blue_sum !== want.blue_sum)
          diffs = {diffs, $sformatf(" blue_sum %0d/%0d", want.blue_sum, got.blue_sum)};
        if (got.opaque_count !== want.opaque_count)
          diffs = {diffs, $sformatf(" opaque_count %0d/%0d", want.opaque_count,
                                    got.opaque_count)};
        if (got.edge_weight !== want.edge_weight)
          diffs = {diffs, $sformatf(" edge_weight %0d/%0d", want.edge_weight,
                                    got.edge_weight)};
        if (got.pixel_total !== want.pixel_total)
          diffs = {diffs, $sformatf(" pixel_total %0d/%0d", want.pixel_total,
                                    got.pixel_total)};
        if (got.edge_total !== want.edge_total)
          diffs = {diffs, $sformatf(" edge_total %0d/%0d", want.edge_total, got.edge_total)};
        if (diffs != "")
          report_failure($sformatf("result %0d expected/actual:%s", results_checked, diffs));
      end
    end
  end

  // Overall time limit, far beyond the clearing pass plus the slowest stalls.
  initial begin
    #5_000_000;
    $display("Run timed out with %0d reads outstanding.", expected_readouts.size());
    $display("FAIL color_histogram_accumulator_core");
    $finish;
  end

endmodule
